/* rtl/cks_pkg.sv */
package cks_pkg;

   localparam int POSITION_BITS = 16;
   localparam int HEADER_BYTES  = 8;
   localparam int ALPHA_COUNT   = 26;
   localparam logic [7:0] LOWER_A = 8'd97;
   localparam logic [7:0] LOWER_Z = 8'd122;
   localparam logic [7:0] UPPER_A = 8'd65;
   localparam logic [7:0] UPPER_Z = 8'd90;

   localparam logic [POSITION_BITS-1:0] POS_OP     = POSITION_BITS'(0);
   localparam logic [POSITION_BITS-1:0] POS_SHIFT  = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_CSUM_L = POSITION_BITS'(2);
   localparam logic [POSITION_BITS-1:0] POS_CSUM_H = POSITION_BITS'(3);
   localparam logic [POSITION_BITS-1:0] POS_PAYLOAD = POSITION_BITS'(HEADER_BYTES);
   localparam logic [POSITION_BITS-1:0] POS_SHORT  = POSITION_BITS'(HEADER_BYTES - 1);
   localparam logic [POSITION_BITS-1:0] POS_MAX    = {POSITION_BITS{1'b1}};

   localparam logic [7:0] OP_FORWARD  = 8'd0;
   localparam logic [7:0] OP_BACKWARD = 8'd1;

   localparam logic [2:0] V_PROGRESS = 3'd0;
   localparam logic [2:0] V_ACCEPT   = 3'd1;
   localparam logic [2:0] V_MISMATCH = 3'd2;
   localparam logic [2:0] V_BAD_OP   = 3'd3;
   localparam logic [2:0] V_SHORT    = 3'd4;

   // header state shared by the control and the letter treatment
   typedef struct packed {
      logic [4:0] rot;
      logic       shift_en;
   } hdr_type;

   // end-around-carry add of one 16-bit word
   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, acc} + {1'b0, word};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

   // signed shift byte taken modulo 26, 0..25
   function automatic logic [4:0] shift_mod(input logic [7:0] b);
      logic [8:0]  v;
      logic [15:0] prod;
      logic [4:0]  q;
      logic [8:0]  r;
      // sv + 130 keeps the residue and makes the value non-negative
      v    = {1'b0, ~b[7], b[6:0]} + 9'd2;
      prod = 16'(v) * 16'd79;
      q    = prod[15:11];
      r    = v - 9'(q * 5'd26);
      return r[4:0];
   endfunction

endpackage

/* rtl/cks_treat.sv */
module cks_treat (
   input  logic [7:0]        in_byte,
   input  cks_pkg::hdr_type  hdr,
   output logic [7:0]        out_byte
);

   logic [7:0] lower;
   logic [5:0] idx;
   logic [5:0] idx_wrap;
   logic       is_letter;

   always_comb begin
      if (in_byte >= cks_pkg::UPPER_A && in_byte <= cks_pkg::UPPER_Z) begin
         lower = in_byte + 8'd32;
      end else begin
         lower = in_byte;
      end
      is_letter = (lower >= cks_pkg::LOWER_A) && (lower <= cks_pkg::LOWER_Z);
      idx = {1'b0, 5'(lower - cks_pkg::LOWER_A)} + {1'b0, hdr.rot};
      if (idx >= 6'(cks_pkg::ALPHA_COUNT)) begin
         idx_wrap = idx - 6'(cks_pkg::ALPHA_COUNT);
      end else begin
         idx_wrap = idx;
      end
      if (is_letter && hdr.shift_en) begin
         out_byte = cks_pkg::LOWER_A + {2'b00, idx_wrap};
      end else begin
         out_byte = lower;
      end
   end

endmodule

/* rtl/cks_ctrl.sv */
module cks_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic [7:0]        payload_byte,
   output cks_pkg::hdr_type  hdr,
   output logic [7:0]        out_byte,
   output logic [2:0]        verdict,
   output logic [15:0]       new_checksum
);

   logic [cks_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic [7:0]  op_ff, op_in;
   logic [4:0]  rot_ff, rot_in;
   logic [15:0] rx_sum_ff, rx_sum_in;
   logic [15:0] isum_ff, isum_in;
   logic [15:0] osum_ff, osum_in;
   logic [7:0]  ib;
   logic [4:0]  kmod;
   logic [15:0] iword, oword;
   logic [15:0] isum_next, osum_next;

   assign hdr.rot      = rot_ff;
   assign hdr.shift_en = (op_ff == cks_pkg::OP_FORWARD) || (op_ff == cks_pkg::OP_BACKWARD);

   always_comb begin
      op_in     = op_ff;
      rot_in    = rot_ff;
      rx_sum_in = rx_sum_ff;
      ib        = in_byte;
      out_byte  = in_byte;
      kmod      = cks_pkg::shift_mod(in_byte);

      priority if (pos_ff == cks_pkg::POS_OP) begin
         op_in = in_byte;
      end else if (pos_ff == cks_pkg::POS_SHIFT) begin
         // direction is folded into the stored rotation
         if (op_ff == cks_pkg::OP_BACKWARD && kmod != 5'd0) begin
            rot_in = 5'(cks_pkg::ALPHA_COUNT) - kmod;
         end else begin
            rot_in = kmod;
         end
      end else if (pos_ff == cks_pkg::POS_CSUM_L) begin
         rx_sum_in = {rx_sum_ff[15:8], in_byte};
         ib        = 8'd0;
         out_byte  = 8'd0;
      end else if (pos_ff == cks_pkg::POS_CSUM_H) begin
         rx_sum_in = {in_byte, rx_sum_ff[7:0]};
         ib        = 8'd0;
         out_byte  = 8'd0;
      end else if (pos_ff >= cks_pkg::POS_PAYLOAD) begin
         out_byte = payload_byte;
      end else begin
         out_byte = in_byte;
      end

      // odd positions carry the high byte of a little-endian word
      iword     = pos_ff[0] ? {ib, 8'd0} : {8'd0, ib};
      oword     = pos_ff[0] ? {out_byte, 8'd0} : {8'd0, out_byte};
      isum_next = cks_pkg::ones_add(isum_ff, iword);
      osum_next = cks_pkg::ones_add(osum_ff, oword);

      if (pos_ff != cks_pkg::POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
      isum_in = isum_next;
      osum_in = osum_next;

      verdict      = cks_pkg::V_PROGRESS;
      new_checksum = 16'd0;
      if (in_last) begin
         priority if (pos_ff < cks_pkg::POS_SHORT) begin
            verdict = cks_pkg::V_SHORT;
         end else if (!((op_in == cks_pkg::OP_FORWARD) || (op_in == cks_pkg::OP_BACKWARD))) begin
            verdict = cks_pkg::V_BAD_OP;
         end else if (~isum_next != rx_sum_in) begin
            verdict = cks_pkg::V_MISMATCH;
         end else begin
            verdict = cks_pkg::V_ACCEPT;
         end
         new_checksum = ~osum_next;
         // message done: back to the idle header state
         pos_in    = '0;
         op_in     = 8'd0;
         rot_in    = 5'd0;
         rx_sum_in = 16'd0;
         isum_in   = 16'd0;
         osum_in   = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         op_ff     <= 8'd0;
         rot_ff    <= 5'd0;
         rx_sum_ff <= 16'd0;
         isum_ff   <= 16'd0;
         osum_ff   <= 16'd0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         op_ff     <= op_in;
         rot_ff    <= rot_in;
         rx_sum_ff <= rx_sum_in;
         isum_ff   <= isum_in;
         osum_ff   <= osum_in;
      end
   end

endmodule

/* rtl/checksummed_caesar_stream_top.sv */
// Checksummed Caesar stream.
// req_*: one message byte per item, req_tlast on the final byte. The first
//   eight bytes are the header: op, signed shift, checksum (little endian),
//   length. Payload letters are lowercased and rotated by the shift if op < 2.
// rsp_*: one item per accepted byte, in order, rsp_tlast copied from the
//   request. The verdict and the new checksum are nonzero only on the final
//   item; the verdict is 1 accept, 2 checksum mismatch, 3 bad op, 4 too short.
// A byte accepted at a clock edge is offered on rsp_* from the result register
//   right after that edge. Throughput is one byte per cycle while no result
//   waits or rsp_tready is high; the ones'-complement sums add each byte.
// A stalled rsp_tready holds the result register; req_tready follows it, so a
//   new byte is taken in the same cycle as the waiting result leaves.
// Synchronous reset empties the result register and clears the header and
//   checksum state, so the next byte is taken as the first of a message.
module checksummed_caesar_stream_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [10:8] verdict,
                                    // [26:11] new_checksum, [31:27] zero
   output logic        rsp_tlast
);

   cks_pkg::hdr_type hdr;
   logic        accept;
   logic [7:0]  payload_byte;
   logic [7:0]  out_byte;
   logic [2:0]  verdict;
   logic [15:0] new_checksum;

   logic        valid_ff, valid_in;
   logic [26:0] data_ff, data_in;
   logic        last_ff, last_in;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   cks_treat u_treat (
      .in_byte  (req_tdata),
      .hdr      (hdr),
      .out_byte (payload_byte)
   );

   cks_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_tdata),
      .in_last      (req_tlast),
      .payload_byte (payload_byte),
      .hdr          (hdr),
      .out_byte     (out_byte),
      .verdict      (verdict),
      .new_checksum (new_checksum)
   );

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      data_in = {new_checksum, verdict, out_byte};
      last_in = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, data_ff};
   assign rsp_tlast  = last_ff;

endmodule

/* tb/checksummed_caesar_stream_top_tb.sv */
module checksummed_caesar_stream_top_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_ITEMS = 670;

   typedef logic [7:0] byte_seq_type[$];

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [2:0]  verdict;
      logic [15:0] csum;
   } cipher_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [7:0] out_byte, [10:8] verdict, [26:11] new_checksum,
                             // [31:27] zero
   logic        rsp_tlast;

   // predictor state
   logic [cks_pkg::POSITION_BITS-1:0] pos_ctr;
   logic [7:0]  hdr_op;
   logic [7:0]  hdr_shift;
   logic [15:0] hdr_csum;
   logic [15:0] in_acc;
   logic [15:0] out_acc;

   cipher_result_type pending_results[$];
   int  errors;
   int  sent_count;
   int  idle_cycles;
   bit  req_gaps_on;
   bit  rsp_gaps_on;
   bit  rsp_hold_request;
   int  rsp_stall_left;

   checksummed_caesar_stream_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, w};
      return s[15:0] + 16'(s[16]);
   endfunction

   // odd positions carry the high byte of a little-endian word
   function automatic logic [15:0] place_word(input logic [7:0] b, input logic odd);
      return odd ? {b, 8'h00} : {8'h00, b};
   endfunction

   function automatic logic [7:0] cipher_letter(input logic [7:0] b);
      int sv;
      int k;
      logic [7:0] c;
      c = b;
      if (c >= cks_pkg::UPPER_A && c <= cks_pkg::UPPER_Z)
         c = c + 8'd32;
      if (c < cks_pkg::LOWER_A || c > cks_pkg::LOWER_Z || hdr_op > cks_pkg::OP_BACKWARD)
         return c;
      sv = $signed(hdr_shift);
      k  = ((sv % cks_pkg::ALPHA_COUNT) + cks_pkg::ALPHA_COUNT) % cks_pkg::ALPHA_COUNT;
      if (hdr_op == cks_pkg::OP_BACKWARD)
         k = (cks_pkg::ALPHA_COUNT - k) % cks_pkg::ALPHA_COUNT;
      return cks_pkg::LOWER_A
             + 8'((int'(c) - int'(cks_pkg::LOWER_A) + k) % cks_pkg::ALPHA_COUNT);
   endfunction

   task automatic clear_predictor();
      pos_ctr   = '0;
      hdr_op    = 8'h00;
      hdr_shift = 8'h00;
      hdr_csum  = 16'h0000;
      in_acc    = 16'h0000;
      out_acc   = 16'h0000;
   endtask

   task automatic predict_cipher(input logic [7:0] b, input logic last);
      cipher_result_type r;
      logic [cks_pkg::POSITION_BITS-1:0] pos;
      logic [7:0] ib;
      logic [7:0] ob;
      pos = pos_ctr;
      ib  = b;
      ob  = b;
      if (pos == cks_pkg::POS_OP)
         hdr_op = b;
      else if (pos == cks_pkg::POS_SHIFT)
         hdr_shift = b;
      else if (pos == cks_pkg::POS_CSUM_L) begin
         hdr_csum[7:0] = b;
         ib = 8'h00;
         ob = 8'h00;
      end else if (pos == cks_pkg::POS_CSUM_H) begin
         hdr_csum[15:8] = b;
         ib = 8'h00;
         ob = 8'h00;
      end else if (pos >= cks_pkg::POS_PAYLOAD)
         ob = cipher_letter(b);
      in_acc  = fold_add(in_acc, place_word(ib, pos[0]));
      out_acc = fold_add(out_acc, place_word(ob, pos[0]));
      if (pos != cks_pkg::POS_MAX)
         pos_ctr = pos + 1'b1;
      r.data    = ob;
      r.last    = last;
      r.verdict = cks_pkg::V_PROGRESS;
      r.csum    = 16'h0000;
      if (last) begin
         if (int'(pos) + 1 < cks_pkg::HEADER_BYTES)
            r.verdict = cks_pkg::V_SHORT;
         else if (hdr_op > cks_pkg::OP_BACKWARD)
            r.verdict = cks_pkg::V_BAD_OP;
         else if (~in_acc != hdr_csum)
            r.verdict = cks_pkg::V_MISMATCH;
         else
            r.verdict = cks_pkg::V_ACCEPT;
         r.csum = ~out_acc;
         clear_predictor();
      end
      pending_results.push_back(r);
   endtask

   // most gaps short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // prediction on the request side, checking on the result side
   always @(posedge clock) begin
      cipher_result_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result item with no prediction pending: %h", rsp_tdata);
               errors++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_tdata[7:0] !== e.data) begin
                  $error("out_byte: expected %0h, got %0h", e.data, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("out_last: expected %0d, got %0d", e.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tdata[10:8] !== e.verdict) begin
                  $error("verdict: expected %0d, got %0d", e.verdict, rsp_tdata[10:8]);
                  errors++;
               end
               if (rsp_tdata[26:11] !== e.csum) begin
                  $error("new_checksum: expected %0h, got %0h", e.csum, rsp_tdata[26:11]);
                  errors++;
               end
               if (rsp_tdata[31:27] !== 5'd0) begin
                  $error("pad: expected 0, got %0h", rsp_tdata[31:27]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_cipher(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("checksummed_caesar_stream_top test failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold on request
   initial begin
      rsp_tready = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_stall_left   = LONG_HOLD;
            rsp_hold_request = 1'b0;
         end
         if (rsp_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_gaps_on)
               rsp_stall_left = gap_len();
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      gap = req_gaps_on ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_message(input byte_seq_type msg);
      foreach (msg[i])
         send_item(msg[i], i == msg.size() - 1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // header plus payload; the checksum field is correct unless good_sum is clear
   function automatic byte_seq_type make_message(input logic [7:0] op, input logic [7:0] shift,
                                                 input byte_seq_type payload, input bit good_sum);
      byte_seq_type m;
      logic [15:0] acc;
      int total;
      total = cks_pkg::HEADER_BYTES + payload.size();
      m.push_back(op);
      m.push_back(shift);
      m.push_back(8'h00);
      m.push_back(8'h00);
      for (int i = 0; i < 4; i++)
         m.push_back(8'(total >> (8 * i)));
      foreach (payload[i])
         m.push_back(payload[i]);
      acc = 16'h0000;
      foreach (m[i])
         acc = fold_add(acc, place_word(m[i], (i % 2) == 1));
      acc = ~acc;
      if (!good_sum)
         acc = acc ^ 16'($urandom_range(1, 65535));
      m[2] = acc[7:0];
      m[3] = acc[15:8];
      return m;
   endfunction

   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return cks_pkg::UPPER_A + 8'($urandom_range(0, 25));
      else if (r < 8)
         return cks_pkg::LOWER_A + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic byte_seq_type random_payload(input int len);
      byte_seq_type p;
      for (int i = 0; i < len; i++)
         p.push_back(payload_byte());
      return p;
   endfunction

   task automatic test_directed();
      byte_seq_type p;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      // lone byte: too short
      p = {8'h00};
      send_message(p);
      // forward, large shift, letters at the case edges
      p = {8'h40, 8'h41, 8'h5A};
      send_message(make_message(cks_pkg::OP_FORWARD, 8'h7F, p, 1'b1));
      // backward, most negative shift, bad checksum
      p = {8'h60, 8'h7A, 8'h7B};
      send_message(make_message(cks_pkg::OP_BACKWARD, 8'h80, p, 1'b0));
      // header only with an unknown op
      p = {};
      send_message(make_message(8'hFF, 8'hE6, p, 1'b1));
      wait_drained();
   endtask

   task automatic test_random_messages();
      byte_seq_type p;
      logic [7:0] op;
      logic [7:0] shift;
      int kind;
      int start;
      start = sent_count;
      while (sent_count - start < RANDOM_ITEMS) begin
         req_gaps_on = $urandom_range(0, 3) != 0;
         rsp_gaps_on = $urandom_range(0, 3) != 0;
         kind = $urandom_range(0, 99);
         if (kind < 6) begin
            // too short: up to seven raw bytes
            p = random_payload(0);
            repeat ($urandom_range(1, cks_pkg::HEADER_BYTES - 1))
               p.push_back(8'($urandom_range(0, 255)));
            send_message(p);
         end else begin
            op = $urandom_range(0, 1) ? cks_pkg::OP_BACKWARD : cks_pkg::OP_FORWARD;
            if (kind < 12)
               op = 8'($urandom_range(2, 255));
            if ($urandom_range(0, 4) == 0)
               shift = 8'($urandom_range(0, 255));
            else
               shift = 8'($urandom_range(0, 52) - cks_pkg::ALPHA_COUNT);
            p = random_payload($urandom_range(0, 30));
            send_message(make_message(op, shift, p, kind >= 20));
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      rsp_hold_request = 1'b1;
      send_message(make_message(cks_pkg::OP_FORWARD, 8'd5, random_payload(40), 1'b1));
      wait_drained();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      errors     = 0;
      sent_count = 0;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      rsp_hold_request = 1'b0;
      clear_predictor();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_messages();
      test_backpressure();

      repeat (10) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("checksummed_caesar_stream_top test passed");
      else
         $display("checksummed_caesar_stream_top test failed");
      $finish;
   end

endmodule
